// ----- hw/rtl/chained_xor_add_header_cipher_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the chained xor/add header cipher unit
// Concurrent checks. Build with NO_ASSERTIONS defined to leave them out.
// ----------------------------------------------------------------------------
`ifndef CHAINED_XOR_ADD_HEADER_CIPHER_UNIT_MACROS_SVH
`define CHAINED_XOR_ADD_HEADER_CIPHER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CHXA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("chxa assertion failed");

// next-cycle implication
`define CHXA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("chxa assertion failed");

`else

`define CHXA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CHXA_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hw/rtl/chxa_pkg.sv -----
// ----------------------------------------------------------------------------
// chxa_pkg
// Opcodes, field widths and the stage-1 record of the header cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package chxa_pkg;

    localparam int OP_W   = 3;
    localparam int KIDX_W = 6;
    localparam int BYTE_W = 8;

    localparam logic [OP_W-1:0] OP_LOAD_KEY   = 3'd0;
    localparam logic [OP_W-1:0] OP_START      = 3'd1;
    localparam logic [OP_W-1:0] OP_SEND       = 3'd2;
    localparam logic [OP_W-1:0] OP_RECV       = 3'd3;
    localparam logic [OP_W-1:0] OP_SAVE_RECV  = 3'd4;
    localparam logic [OP_W-1:0] OP_RESTORE_RX = 3'd5;

    // beat held in stage 1 while the key byte comes out of the table
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic              enabled;
    } s1_beat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/chained_xor_add_header_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// chained_xor_add_header_cipher_unit
// Byte-wise xor/add chained cipher for link headers, key table in RAM.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload                   | beats
//  --------+--------------------+---------------------------+------------------
//  in      | in_valid/in_stall  | op, key_index, data_byte  | one per command
//  out     | out_valid/out_stall| out_byte                  | one per send/recv
//
//  One beat per cycle while the output does not stall. The key table read is
//  issued as a send or receive beat is accepted into stage 1; stage 1 then
//  loads out_byte, from which the result is taken.
//  Key indices and the enable flag update at accept; chain bytes update in
//  stage 1 when the key byte is there, so consecutive beats chain correctly.
//  Reset clears indices, chain bytes and the enable flag, not the key table.
//  A stalled output holds stage 1; in_stall rises only when stage 1 is full
//  and its result cannot move into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chained_xor_add_header_cipher_unit_macros.svh"

module chained_xor_add_header_cipher_unit #(
    parameter int KEY_BYTES = 40
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [chxa_pkg::OP_W-1:0]       op,
    input  wire logic [chxa_pkg::KIDX_W-1:0]     key_index,
    input  wire logic [chxa_pkg::BYTE_W-1:0]     data_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [chxa_pkg::BYTE_W-1:0]     out_byte
);

    localparam int IDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_BYTES - 1);
    localparam logic [chxa_pkg::KIDX_W:0] KEY_LIMIT = (chxa_pkg::KIDX_W + 1)'(KEY_BYTES);

    // ---------------- stage 0: accept, index update, table access ----------
    logic in_fire;
    logic cipher_en_reg,  cipher_en_next;
    logic [IDX_W-1:0] send_idx_reg,  send_idx_next;
    logic [IDX_W-1:0] recv_idx_reg,  recv_idx_next;
    logic [IDX_W-1:0] saved_idx_reg, saved_idx_next;

    logic                        key_wr_en;
    logic                        key_rd_en;
    logic [IDX_W-1:0]            key_rd_addr;
    logic [chxa_pkg::BYTE_W-1:0] key_byte;

    assign in_fire = in_valid && !in_stall;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        next_idx = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
    endfunction

    always_comb
    begin
        cipher_en_next = cipher_en_reg;
        send_idx_next  = send_idx_reg;
        recv_idx_next  = recv_idx_reg;
        saved_idx_next = saved_idx_reg;
        key_wr_en      = 1'b0;
        key_rd_en      = 1'b0;
        key_rd_addr    = send_idx_reg;
        if (in_fire)
        begin
            unique case (op)
                chxa_pkg::OP_LOAD_KEY:
                begin
                    key_wr_en = ({1'b0, key_index} < KEY_LIMIT);
                end
                chxa_pkg::OP_START:
                begin
                    send_idx_next  = '0;
                    recv_idx_next  = '0;
                    cipher_en_next = 1'b1;
                end
                chxa_pkg::OP_SEND:
                begin
                    key_rd_en   = 1'b1;
                    key_rd_addr = send_idx_reg;
                    if (cipher_en_reg)
                    begin
                        send_idx_next = next_idx(send_idx_reg);
                    end
                end
                chxa_pkg::OP_RECV:
                begin
                    key_rd_en   = 1'b1;
                    key_rd_addr = recv_idx_reg;
                    if (cipher_en_reg)
                    begin
                        recv_idx_next = next_idx(recv_idx_reg);
                    end
                end
                chxa_pkg::OP_SAVE_RECV:
                begin
                    saved_idx_next = recv_idx_reg;
                end
                chxa_pkg::OP_RESTORE_RX:
                begin
                    recv_idx_next = saved_idx_reg;
                end
                default:
                begin
                    // unused opcodes: no effect
                end
            endcase
        end
    end

    chxa_key_ram #(
        .DEPTH (KEY_BYTES),
        .AW    (IDX_W)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (key_index[IDX_W-1:0]),
        .wr_data (data_byte),
        .rd_en   (key_rd_en),
        .rd_addr (key_rd_addr),
        .rd_data (key_byte)
    );

    // ---------------- stage 1: chain update and result ---------------------
    logic                 s1_valid_reg, s1_valid_next;
    chxa_pkg::s1_beat_t   s1_reg, s1_next;
    logic                 s1_has_result;
    logic                 s1_adv;
    logic                 s1_fire;

    logic [chxa_pkg::BYTE_W-1:0] send_chain_reg,  send_chain_next;
    logic [chxa_pkg::BYTE_W-1:0] recv_chain_reg,  recv_chain_next;
    logic [chxa_pkg::BYTE_W-1:0] saved_chain_reg, saved_chain_next;
    logic [chxa_pkg::BYTE_W-1:0] s1_result;

    logic                        out_valid_reg, out_valid_next;
    logic [chxa_pkg::BYTE_W-1:0] out_byte_reg,  out_byte_next;

    assign s1_has_result = (s1_reg.op == chxa_pkg::OP_SEND) || (s1_reg.op == chxa_pkg::OP_RECV);
    assign s1_adv        = !s1_has_result || !out_valid_reg || !out_stall;
    assign s1_fire       = s1_valid_reg && s1_adv;
    assign in_stall      = s1_valid_reg && !s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_next       = s1_reg;
        if (in_fire)
        begin
            s1_valid_next   = 1'b1;
            s1_next.op      = op;
            s1_next.data    = data_byte;
            s1_next.enabled = cipher_en_reg;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        send_chain_next  = send_chain_reg;
        recv_chain_next  = recv_chain_reg;
        saved_chain_next = saved_chain_reg;
        s1_result        = s1_reg.data;
        if (s1_fire)
        begin
            unique case (s1_reg.op)
                chxa_pkg::OP_START:
                begin
                    send_chain_next = '0;
                    recv_chain_next = '0;
                end
                chxa_pkg::OP_SEND:
                begin
                    if (s1_reg.enabled)
                    begin
                        s1_result       = (s1_reg.data ^ key_byte) + send_chain_reg;
                        send_chain_next = s1_result;
                    end
                end
                chxa_pkg::OP_RECV:
                begin
                    if (s1_reg.enabled)
                    begin
                        s1_result       = (s1_reg.data - recv_chain_reg) ^ key_byte;
                        recv_chain_next = s1_reg.data;
                    end
                end
                chxa_pkg::OP_SAVE_RECV:
                begin
                    saved_chain_next = recv_chain_reg;
                end
                chxa_pkg::OP_RESTORE_RX:
                begin
                    recv_chain_next = saved_chain_reg;
                end
                default:
                begin
                    // key loads and unused opcodes: nothing here
                end
            endcase
        end
    end

    // ---------------- output register --------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        if (s1_fire && s1_has_result)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = s1_result;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // ---------------- registers --------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_en_reg   <= 1'b0;
            send_idx_reg    <= '0;
            recv_idx_reg    <= '0;
            saved_idx_reg   <= '0;
            send_chain_reg  <= '0;
            recv_chain_reg  <= '0;
            saved_chain_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cipher_en_reg   <= cipher_en_next;
            send_idx_reg    <= send_idx_next;
            recv_idx_reg    <= recv_idx_next;
            saved_idx_reg   <= saved_idx_next;
            send_chain_reg  <= send_chain_next;
            recv_chain_reg  <= recv_chain_next;
            saved_chain_reg <= saved_chain_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg       <= s1_next;
        out_byte_reg <= out_byte_next;
    end

    // ---------------- assertions -------------------------------------------
    `CHXA_ASSERT_IMP(a_send_idx_range, clk, rst_n, 1'b1, send_idx_reg <= LAST_IDX)
    `CHXA_ASSERT_IMP(a_recv_idx_range, clk, rst_n, 1'b1, recv_idx_reg <= LAST_IDX)
    `CHXA_ASSERT_NXT(a_accept_to_s1, clk, rst_n, in_fire, s1_valid_reg)
    `CHXA_ASSERT_NXT(a_enable_sticky, clk, rst_n, cipher_en_reg, cipher_en_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/chxa_key_ram.sv -----
// ----------------------------------------------------------------------------
// chxa_key_ram
// Key table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chxa_key_ram #(
    parameter int DEPTH = 40,
    parameter int AW    = 6
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [chxa_pkg::BYTE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [chxa_pkg::BYTE_W-1:0] rd_data
);

    logic [chxa_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
